/* src/mexp_pkg.sv */
`default_nettype none

package mexp_pkg;

    // Width of base, exponent, modulus and result
    localparam int OPERAND_BITS = 31;

    // Bit counter width: indexes 0 .. OPERAND_BITS-1
    localparam int CNT_BITS = $clog2(OPERAND_BITS);

    typedef logic [OPERAND_BITS-1:0] operand_t;
    typedef logic [CNT_BITS-1:0]     bit_cnt_t;

endpackage

`default_nettype wire

/* src/mexp_mulmod.sv */
`default_nettype none

// Bit-serial interleaved modular multiply: p = (a * b) mod m.
// Scans b from its top bit, one bit per MM_DBL/MM_ADD state pair.
// Needs a <= m and m nonzero.
module mexp_mulmod
    import mexp_pkg::*;
(
    input  wire      aclk,
    input  wire      aresetn,
    input  wire      start,
    input  operand_t a,
    input  operand_t b,
    input  operand_t m,
    output logic     done,
    output operand_t p
);

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_DBL,
        MM_ADD
    } mm_state_t;

    mm_state_t state_reg;
    logic      done_reg;
    operand_t  r_reg;
    operand_t  a_reg;
    operand_t  b_reg;
    operand_t  m_reg;
    bit_cnt_t  cnt_reg;

    logic [OPERAND_BITS:0] dbl_sum;
    logic [OPERAND_BITS:0] add_sum;
    logic [OPERAND_BITS:0] sum;
    logic [OPERAND_BITS:0] m_ext;
    operand_t              r_next;

    always_comb begin
        m_ext   = {1'b0, m_reg};
        dbl_sum = {r_reg, 1'b0};
        add_sum = {1'b0, r_reg} + (b_reg[OPERAND_BITS-1] ? {1'b0, a_reg} : '0);
        sum     = (state_reg == MM_DBL) ? dbl_sum : add_sum;
        // Partial result stays below 2m, so one conditional subtract reduces it
        if (sum >= m_ext) begin
            r_next = OPERAND_BITS'(sum - m_ext);
        end else begin
            r_next = sum[OPERAND_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                MM_IDLE: begin
                    if (start) begin
                        r_reg     <= '0;
                        a_reg     <= a;
                        b_reg     <= b;
                        m_reg     <= m;
                        cnt_reg   <= '0;
                        state_reg <= MM_DBL;
                    end
                end
                MM_DBL: begin
                    r_reg     <= r_next;
                    state_reg <= MM_ADD;
                end
                MM_ADD: begin
                    r_reg <= r_next;
                    b_reg <= {b_reg[OPERAND_BITS-2:0], 1'b0};
                    if (cnt_reg == CNT_BITS'(OPERAND_BITS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= MM_IDLE;
                    end else begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= MM_DBL;
                    end
                end
                default: begin
                    state_reg <= MM_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign p    = r_reg;

endmodule

`default_nettype wire

/* src/modular_exponentiation_unit_top.sv */
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_base, s_exponent
// m_        out        m_valid / m_ready   m_power
// cfg_      in         cfg_we (no wait)    cfg_wdata (modulus)
//
// A request, once accepted, first reduces the base with one multiplier pass, then
// steps through 31 exponent bits with one pass each of the bit-serial multipliers
// (two running side by side for square and multiply), then loads the result.
// s_ready is high only when idle, so the next request waits until that result is loaded.
// Reset (synchronous, aresetn low) sets the modulus to 2 and empties the block.
// A finished result waits in the output register; a new request is taken
// meanwhile, and the block only stalls at its end if that result is still held.
`default_nettype none

module modular_exponentiation_unit_top
    import mexp_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_we,
    input  wire [OPERAND_BITS-1:0] cfg_wdata,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire [OPERAND_BITS-1:0] s_base,
    input  wire [OPERAND_BITS-1:0] s_exponent,
    output logic                   m_valid,
    input  wire                    m_ready,
    output logic [OPERAND_BITS-1:0] m_power
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RED,
        ST_LOOP,
        ST_OUT
    } state_t;

    state_t   state_reg;
    operand_t modulus_reg;
    operand_t base_reg;
    operand_t exp_reg;
    operand_t acc_reg;
    operand_t sq_reg;
    bit_cnt_t bit_cnt_reg;
    logic     start_reg;
    logic     m_valid_reg;
    operand_t m_power_reg;

    operand_t mul0_a;
    operand_t mul0_b;
    logic     mul0_done;
    logic     mul1_done;
    operand_t mul0_p;
    operand_t mul1_p;

    // Reduction pass multiplies the base by one; the loop multiplies acc by sq
    assign mul0_a = (state_reg == ST_RED) ? operand_t'(1) : acc_reg;
    assign mul0_b = (state_reg == ST_RED) ? base_reg : sq_reg;

    mexp_mulmod u_mul_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .a       (mul0_a),
        .b       (mul0_b),
        .m       (modulus_reg),
        .done    (mul0_done),
        .p       (mul0_p)
    );

    mexp_mulmod u_mul_sq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg && (state_reg == ST_LOOP)),
        .a       (sq_reg),
        .b       (sq_reg),
        .m       (modulus_reg),
        .done    (mul1_done),
        .p       (mul1_p)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            modulus_reg <= operand_t'(2);
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            bit_cnt_reg <= '0;
        end else begin
            start_reg <= 1'b0;
            if (cfg_we) begin
                modulus_reg <= cfg_wdata;
            end
            // ST_OUT reloads the output register itself
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        base_reg  <= s_base;
                        exp_reg   <= s_exponent;
                        start_reg <= 1'b1;
                        state_reg <= ST_RED;
                    end
                end
                ST_RED: begin
                    if (mul0_done) begin
                        sq_reg      <= mul0_p;
                        acc_reg     <= (modulus_reg == operand_t'(1)) ? '0 : operand_t'(1);
                        bit_cnt_reg <= '0;
                        start_reg   <= 1'b1;
                        state_reg   <= ST_LOOP;
                    end
                end
                ST_LOOP: begin
                    if (mul0_done) begin
                        if (exp_reg[0]) begin
                            acc_reg <= mul0_p;
                        end
                        sq_reg  <= mul1_p;
                        exp_reg <= exp_reg >> 1;
                        if (bit_cnt_reg == CNT_BITS'(OPERAND_BITS - 1)) begin
                            state_reg <= ST_OUT;
                        end else begin
                            bit_cnt_reg <= bit_cnt_reg + 1'b1;
                            start_reg   <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_power_reg <= (modulus_reg == '0) ? '0 : acc_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_power = m_power_reg;

`ifndef SYNTHESIS
    a_mul_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOP) |-> (mul0_done == mul1_done))
        else $error("square and multiply units out of step");

    a_acc_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOP && modulus_reg > operand_t'(1)) |->
            (acc_reg < modulus_reg && sq_reg < modulus_reg))
        else $error("accumulator or square not reduced");

    a_power_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && modulus_reg != '0) |-> (m_power < modulus_reg))
        else $error("result not below modulus");

    a_start_once: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |=> !start_reg)
        else $error("multiplier start held for two cycles");
`endif

endmodule

`default_nettype wire

/* tb/tb_modular_exponentiation_unit_top.sv */
module tb_modular_exponentiation_unit_top
    import mexp_pkg::*;
();

    localparam int MAX_IDLE      = 20000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 2200;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 45;
    localparam int DIRECTED_ROWS = 21;
    localparam int REPORT_LIMIT  = 10;

    localparam operand_t OPERAND_MAX = '1;
    localparam operand_t RSA_N       = 31'd3233;
    localparam operand_t CHECKER_MOD = 31'h5555_5555;

    typedef struct packed {
        operand_t modulus;
        operand_t base;
        operand_t exponent;
        logic     typed;
        operand_t power;
    } directed_row_t;

    typedef struct {
        operand_t base;
        operand_t exponent;
        operand_t modulus;
        operand_t power;
    } power_entry_t;

    // modulus, base, exponent, typed, power (power only used where typed)
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{31'd2, 31'd3, 31'd0, 1'b1, 31'd1},
        '{31'd2, 31'd3, 31'd1, 1'b1, 31'd1},
        '{31'd2, 31'd2, 31'd5, 1'b1, 31'd0},
        '{31'd2, OPERAND_MAX, OPERAND_MAX, 1'b1, 31'd1},
        // zero modulus: nothing to reduce against, result held at zero
        '{31'd0, 31'd5, 31'd3, 1'b1, 31'd0},
        '{31'd0, OPERAND_MAX, OPERAND_MAX, 1'b1, 31'd0},
        // modulus one: even a zero exponent gives zero
        '{31'd1, 31'd7, 31'd0, 1'b1, 31'd0},
        '{31'd1, OPERAND_MAX, 31'd9, 1'b1, 31'd0},
        '{OPERAND_MAX, 31'd0, 31'd0, 1'b1, 31'd1},
        '{OPERAND_MAX, 31'd0, 31'd5, 1'b1, 31'd0},
        '{OPERAND_MAX, 31'd1, OPERAND_MAX, 1'b1, 31'd1},
        '{OPERAND_MAX, OPERAND_MAX, 31'd1, 1'b1, 31'd0},
        '{OPERAND_MAX, 31'h7FFF_FFFE, 31'd2, 1'b1, 31'd1},
        '{OPERAND_MAX, 31'd2, 31'd31, 1'b1, 31'd1},
        '{OPERAND_MAX, 31'd3, OPERAND_MAX, 1'b0, 31'd0},
        '{OPERAND_MAX, 31'd12345, 31'h5555_5555, 1'b0, 31'd0},
        // classic RSA pair, n = 61 * 53, e = 17, d = 2753
        '{RSA_N, 31'd65, 31'd17, 1'b1, 31'd2790},
        '{RSA_N, 31'd2790, 31'd2753, 1'b1, 31'd65},
        '{RSA_N, 31'd4000, 31'd1, 1'b1, 31'd767},
        '{CHECKER_MOD, 31'h2AAA_AAAA, 31'h2AAA_AAAA, 1'b0, 31'd0},
        '{CHECKER_MOD, 31'h7FFF_0000, 31'h0000_FFFF, 1'b0, 31'd0}
    };

    logic     aclk       = 1'b0;
    logic     aresetn    = 1'b0;
    logic     cfg_we     = 1'b0;
    operand_t cfg_wdata  = '0;
    logic     s_valid    = 1'b0;
    logic     s_ready;
    operand_t s_base     = '0;
    operand_t s_exponent = '0;
    logic     m_valid;
    logic     m_ready    = 1'b0;
    operand_t m_power;

    power_entry_t expected_powers[$];
    operand_t     modulus_now = 31'd2;

    int burst_left      = 0;
    int requests_sent   = 0;
    int results_seen    = 0;
    int modulus_writes  = 0;
    int error_count     = 0;
    int idle_cycles     = 0;
    int ready_mode      = 0;
    int ready_mode_left = 0;
    int stall_left      = 0;

    always #5 aclk = ~aclk;

    modular_exponentiation_unit_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_base     (s_base),
        .s_exponent (s_exponent),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_power    (m_power)
    );

    // Square-and-multiply with the base reduced first; 64-bit products cannot overflow.
    function automatic operand_t predict_power(operand_t base, operand_t exponent,
                                               operand_t modulus);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] m64;
        if (modulus == '0)
            return '0;
        m64 = 64'(modulus);
        acc = 64'd1 % m64;
        sq  = 64'(base) % m64;
        for (int i = 0; i < OPERAND_BITS; i++) begin
            if (exponent[i])
                acc = (acc * sq) % m64;
            sq = (sq * sq) % m64;
        end
        return operand_t'(acc);
    endfunction

    task automatic note_failure(string what, power_entry_t entry);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%s: base %0d exponent %0d modulus %0d: expected %0d, got %0d",
                     what, entry.base, entry.exponent, entry.modulus, entry.power, m_power);
    endtask

    task automatic send_request(operand_t base, operand_t exponent, logic typed,
                                operand_t power);
        int gap;
        power_entry_t entry;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(100, 2500);
                default: gap = $urandom_range(1, 20);
            endcase
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_base     = base;
        s_exponent = exponent;
        s_valid    = 1'b1;
        do @(posedge aclk); while (!s_ready);
        entry.base     = base;
        entry.exponent = exponent;
        entry.modulus  = modulus_now;
        entry.power    = typed ? power : predict_power(base, exponent, modulus_now);
        expected_powers.push_back(entry);
        requests_sent++;
        @(negedge aclk);
    endtask

    // Hold off new requests until every outstanding power has come back.
    task automatic wait_for_results();
        s_valid = 1'b0;
        while (expected_powers.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_modulus(operand_t value);
        wait_for_results();
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we      = 1'b0;
        modulus_now = value;
        modulus_writes++;
    endtask

    always @(posedge aclk) begin : check_results
        power_entry_t entry;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_powers.size() == 0) begin
                entry = '{default: '0};
                note_failure("unexpected result", entry);
            end else begin
                entry = expected_powers.pop_front();
                if (m_power !== entry.power)
                    note_failure("power mismatch", entry);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= MAX_IDLE) begin
                $display("timeout: no request or result moved for %0d cycles", MAX_IDLE);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver: switch between always ready, random chatter and long stalls.
    always @(negedge aclk) begin
        if (ready_mode_left == 0) begin
            ready_mode      = $urandom_range(0, 3);
            ready_mode_left = $urandom_range(50, 3000);
        end
        ready_mode_left--;
        case (ready_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    m_ready <= 1'b0;
                    stall_left--;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        stall_left = $urandom_range(100, 2500);
                end
            end
        endcase
    end

    initial begin : stimulus
        operand_t base;
        operand_t exponent;
        operand_t modulus;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_rows[i].modulus != modulus_now)
                write_modulus(directed_rows[i].modulus);
            send_request(directed_rows[i].base, directed_rows[i].exponent,
                         directed_rows[i].typed, directed_rows[i].power);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       modulus = operand_t'($urandom) | 31'h4000_0000;
                1:       modulus = operand_t'($urandom_range(2, 64));
                2:       modulus = OPERAND_MAX;
                3:       modulus = 31'h4000_0000;
                4:       modulus = operand_t'($urandom_range(2, 65535));
                default: modulus = operand_t'($urandom);
            endcase
            write_modulus(modulus);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 3))
                    0:       base = operand_t'($urandom);
                    1:       base = operand_t'($urandom_range(0, 255));
                    // straddle the modulus to exercise the initial reduction
                    2:       base = modulus_now + operand_t'($urandom_range(0, 2)) - 31'd1;
                    default: base = $urandom_range(0, 1) ? OPERAND_MAX : '0;
                endcase
                case ($urandom_range(0, 4))
                    0, 1:    exponent = operand_t'($urandom);
                    2:       exponent = operand_t'($urandom_range(0, 16));
                    3:       exponent = '0;
                    default: exponent = OPERAND_MAX - operand_t'($urandom_range(0, 3));
                endcase
                send_request(base, exponent, 1'b0, '0);
                if ($urandom_range(0, 39) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("%0d requests over %0d modulus settings (zero, one, two, full scale, RSA)",
                 requests_sent, modulus_writes + 1);
        $display("%0d powers compared, %0d failures", results_seen, error_count);
        if (error_count == 0 && expected_powers.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
